### hdl/lis_pkg.sv
// Shared constants and types for the longest increasing subsequence block.
// No dependencies; lis_ifs.sv and longest_increasing_subsequence.sv refer to this package by scoped name.

package lis_pkg;

    // Tail store geometry
    localparam int MAX_LEN = 1024;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    // Field widths
    localparam int VAL_W = 32;
    localparam int LEN_W = 11;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_CMP,
        ST_UPD,
        ST_RES
    } t_state;

endpackage

### hdl/lis_ifs.sv
// Request and result channel interfaces for the longest increasing subsequence block.
// Depends on lis_pkg for field widths.

interface lis_req_if;
    logic                              valid;
    logic                              ready;
    logic signed [lis_pkg::VAL_W-1:0]  value;
    logic                              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface lis_res_if;
    logic                        valid;
    logic                        ready;
    logic [lis_pkg::LEN_W-1:0]   length;
    logic                        overflow;
    logic                        done_res;

    modport source (output valid, output length, output overflow, output done_res,
                    input ready);
    modport sink   (input valid, input length, input overflow, input done_res,
                    output ready);
endinterface

### hdl/lis_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.

module lis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/longest_increasing_subsequence.sv
// Longest strictly increasing subsequence over a stream of signed values.
// Depends on lis_pkg, lis_req_if / lis_res_if and the lis_ram tail store.
//
// Usage:
//   i_req carries one request per sequence element: value (signed 32 bit) and
//   last, which marks the final element of a sequence. o_res returns exactly
//   one result per request: length (current LIS length), overflow (an append
//   was dropped in this sequence because the tail store was full) and
//   done_res (result of the element marked last).
// Search:
//   A request is searched by binary search over the tails in use, one tail
//   per probe (ST_SRCH issues the read address, then ST_CMP compares against
//   the registered RAM data). The single read port of the tail RAM and the
//   single comparator allow only one probe at a time. One request is in work
//   at a time; the next is taken in the cycle after its result is handed to
//   the output register.
// Reset:
//   i_rst_n (synchronous, active low) clears the tail count, the overflow
//   flag, the sequencer and the result valid flag. Tail contents are not cleared.
// Stall:
//   A result sits in an output register until taken. A new request is
//   accepted meanwhile; its result waits in the final step until the output
//   register frees up.

module longest_increasing_subsequence (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lis_req_if.sink       i_req,
    lis_res_if.source     o_res
);

    lis_pkg::t_state r_state, n_state;

    logic signed [lis_pkg::VAL_W-1:0] r_value, n_value;
    logic                             r_last,  n_last;
    logic [lis_pkg::CNT_W-1:0]        r_lo,    n_lo;
    logic [lis_pkg::CNT_W-1:0]        r_hi,    n_hi;
    logic [lis_pkg::IDX_W-1:0]        r_mid,   n_mid;
    logic [lis_pkg::CNT_W-1:0]        r_count, n_count;
    logic                             r_ovf,   n_ovf;

    logic                             r_out_valid, n_out_valid;
    logic [lis_pkg::LEN_W-1:0]        r_len,       n_len;
    logic                             r_out_ovf,   n_out_ovf;
    logic                             r_done,      n_done;

    logic                             w_we;
    logic [lis_pkg::IDX_W-1:0]        w_waddr;
    logic [lis_pkg::IDX_W-1:0]        w_raddr;
    logic [lis_pkg::VAL_W-1:0]        w_rdata;
    logic [lis_pkg::CNT_W:0]          w_sum;

    // Tail store
    lis_ram #(
        .WIDTH (lis_pkg::VAL_W),
        .DEPTH (lis_pkg::MAX_LEN)
    ) u_tails (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Midpoint of the current search window
    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};

    // State and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lis_pkg::ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_value   <= n_value;
        r_last    <= n_last;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_len     <= n_len;
        r_out_ovf <= n_out_ovf;
        r_done    <= n_done;
    end

    // Sequencer: accept, search, update, report
    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_last      = r_last;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_len       = r_len;
        n_out_ovf   = r_out_ovf;
        n_done      = r_done;
        n_out_valid = r_out_valid && !o_res.ready;
        w_we        = 1'b0;
        w_waddr     = r_lo[lis_pkg::IDX_W-1:0];
        w_raddr     = w_sum[lis_pkg::IDX_W:1];
        i_req.ready = 1'b0;

        unique case (r_state)
            lis_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_value = i_req.value;
                    n_last  = i_req.last;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = lis_pkg::ST_SRCH;
                end
            end
            lis_pkg::ST_SRCH: begin
                // Issue read of the midpoint, or finish the search
                if (r_lo < r_hi) begin
                    n_mid   = w_sum[lis_pkg::IDX_W:1];
                    n_state = lis_pkg::ST_CMP;
                end else begin
                    n_state = lis_pkg::ST_UPD;
                end
            end
            lis_pkg::ST_CMP: begin
                // Narrow the window on the registered tail
                if ($signed(w_rdata) < r_value) begin
                    n_lo = lis_pkg::CNT_W'(r_mid) + lis_pkg::CNT_W'(1);
                end else begin
                    n_hi = lis_pkg::CNT_W'(r_mid);
                end
                n_state = lis_pkg::ST_SRCH;
            end
            lis_pkg::ST_UPD: begin
                // Replace a tail, append, or drop when full
                if (r_lo < r_count) begin
                    w_we = 1'b1;
                end else if (r_count < lis_pkg::CNT_W'(lis_pkg::MAX_LEN)) begin
                    w_we    = 1'b1;
                    n_count = r_count + lis_pkg::CNT_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
                n_state = lis_pkg::ST_RES;
            end
            lis_pkg::ST_RES: begin
                // Hand the result to the output register once it is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_len       = lis_pkg::LEN_W'(r_count);
                    n_out_ovf   = r_ovf;
                    n_done      = r_last;
                    if (r_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                    n_state = lis_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lis_pkg::ST_IDLE;
            end
        endcase
    end

    // Result channel
    assign o_res.valid    = r_out_valid;
    assign o_res.length   = r_len;
    assign o_res.overflow = r_out_ovf;
    assign o_res.done_res = r_done;

endmodule
